>>> rtl/sxlt_pkg.sv
// ----------------------------------------------------------------------------
// Shared/exclusive lock table - common package
// Field widths, request and status codes, and the scan flag group.
// ----------------------------------------------------------------------------
package sxlt_pkg;

   localparam int REQ_TYPE_W   = 2;
   localparam int KEY_W        = 48;
   localparam int STATUS_W     = 2;
   localparam int LOCK_COUNT_W = 8;

   // request codes
   localparam logic [REQ_TYPE_W-1:0] REQ_SHARED    = 2'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_EXCLUSIVE = 2'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_UNLOCK    = 2'd2;

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_CONFLICT  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_SATURATED = 2'd3;

   // flags handed from the scanner to the controller
   typedef struct packed {
      logic done;        // one-cycle pulse: whole table searched
      logic hit;         // key found in a valid entry
      logic free_found;  // at least one free entry seen
   } scan_flags_type;

endpackage

>>> rtl/sxlt_ram.sv
// ----------------------------------------------------------------------------
// Shared/exclusive lock table - generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sxlt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/sxlt_scan.sv
// ----------------------------------------------------------------------------
// Shared/exclusive lock table - table scanner
// Walks every entry through the RAM read port, one a cycle, and records the
// matching entry and the lowest free entry.
// ----------------------------------------------------------------------------
module sxlt_scan #(
   parameter int ENTRIES = 64,
   parameter int COUNT_W = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [sxlt_pkg::KEY_W-1:0]      key,
   output logic                            rd_en,
   output logic [$clog2(ENTRIES)-1:0]      rd_addr,
   input  logic [sxlt_pkg::KEY_W+COUNT_W:0] rd_data,
   output sxlt_pkg::scan_flags_type        flags,
   output logic [$clog2(ENTRIES)-1:0]      hit_idx,
   output logic signed [COUNT_W-1:0]       hit_count,
   output logic [$clog2(ENTRIES)-1:0]      free_idx
);

   localparam int IW = $clog2(ENTRIES);
   localparam int WW = sxlt_pkg::KEY_W + COUNT_W + 1;
   localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

   logic                      issue_ff, issue_in;
   logic [IW-1:0]             addr_ff, addr_in;
   logic                      chk_ff, chk_in;
   logic [IW-1:0]             chk_idx_ff, chk_idx_in;
   logic                      done_ff, done_in;
   logic                      hit_ff, hit_in;
   logic [IW-1:0]             hit_idx_ff, hit_idx_in;
   logic signed [COUNT_W-1:0] hit_count_ff, hit_count_in;
   logic                      free_ff, free_in;
   logic [IW-1:0]             free_idx_ff, free_idx_in;

   logic                      ent_valid;
   logic [sxlt_pkg::KEY_W-1:0] ent_key;
   logic signed [COUNT_W-1:0] ent_count;

   assign ent_valid = rd_data[WW-1];
   assign ent_key   = rd_data[WW-2:COUNT_W];
   assign ent_count = rd_data[COUNT_W-1:0];

   always_comb begin
      issue_in     = issue_ff;
      addr_in      = addr_ff;
      chk_in       = issue_ff;
      chk_idx_in   = addr_ff;
      done_in      = chk_ff && (chk_idx_ff == LAST_IDX);
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      hit_count_in = hit_count_ff;
      free_in      = free_ff;
      free_idx_in  = free_idx_ff;

      if (start) begin
         issue_in = 1'b1;
         addr_in  = '0;
         hit_in   = 1'b0;
         free_in  = 1'b0;
      end else if (issue_ff) begin
         if (addr_ff == LAST_IDX) begin
            issue_in = 1'b0;
         end else begin
            addr_in = addr_ff + IW'(1);
         end
      end

      // word read last cycle is on rd_data now
      if (chk_ff) begin
         if (ent_valid && (ent_key == key) && !hit_ff) begin
            hit_in       = 1'b1;
            hit_idx_in   = chk_idx_ff;
            hit_count_in = ent_count;
         end
         if (!ent_valid && !free_ff) begin
            free_in     = 1'b1;
            free_idx_in = chk_idx_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         issue_ff <= 1'b0;
         chk_ff   <= 1'b0;
         done_ff  <= 1'b0;
         hit_ff   <= 1'b0;
         free_ff  <= 1'b0;
      end else begin
         issue_ff <= issue_in;
         chk_ff   <= chk_in;
         done_ff  <= done_in;
         hit_ff   <= hit_in;
         free_ff  <= free_in;
      end
      addr_ff      <= addr_in;
      chk_idx_ff   <= chk_idx_in;
      hit_idx_ff   <= hit_idx_in;
      hit_count_ff <= hit_count_in;
      free_idx_ff  <= free_idx_in;
   end

   assign rd_en            = issue_ff;
   assign rd_addr          = addr_ff;
   assign flags.done       = done_ff;
   assign flags.hit        = hit_ff;
   assign flags.free_found = free_ff;
   assign hit_idx          = hit_idx_ff;
   assign hit_count        = hit_count_ff;
   assign free_idx         = free_idx_ff;

endmodule

>>> rtl/shared_exclusive_lock_table_core.sv
// ----------------------------------------------------------------------------
// Shared/exclusive lock table - top level
// Lock table keyed by block id; grants shared and exclusive locks, unlocks,
// and reports conflicts, a full table or a saturated shared count.
// ----------------------------------------------------------------------------
//  channel | dir | handshake             | word
//  req_    | in  | req_valid / req_stall  | req_type, req_block_key
//  rsp_    | out | rsp_valid / rsp_stall  | rsp_status, rsp_lock_count
//
//  Each word walks the full entry RAM through its single read port, one
//  entry a cycle, then makes its table update in ST_DECIDE.
//  After reset a clearing pass writes every entry invalid, req_stall high.
//  A finished word waits in the output register; the next request is taken
//  meanwhile, and only the update stalls while rsp_stall holds.
// ----------------------------------------------------------------------------
module shared_exclusive_lock_table_core #(
   parameter int TABLE_ENTRIES = 64,
   parameter int MAX_SHARED    = 127
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [sxlt_pkg::REQ_TYPE_W-1:0]     req_type,
   input  logic [sxlt_pkg::KEY_W-1:0]          req_block_key,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [sxlt_pkg::STATUS_W-1:0]       rsp_status,
   output logic signed [sxlt_pkg::LOCK_COUNT_W-1:0] rsp_lock_count
);

   localparam int IW = $clog2(TABLE_ENTRIES);
   localparam int CW = $clog2(MAX_SHARED + 1) + 1;
   localparam int KW = sxlt_pkg::KEY_W;
   localparam int WW = KW + CW + 1;
   localparam int XW = (CW > sxlt_pkg::LOCK_COUNT_W) ? CW : sxlt_pkg::LOCK_COUNT_W;
   localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);
   localparam logic signed [CW-1:0] CNT_MAX  = CW'(MAX_SHARED);
   localparam logic signed [CW-1:0] CNT_ONE  = CW'(1);
   localparam logic signed [CW-1:0] CNT_EXCL = '1;

   localparam logic [1:0] ST_CLEAR  = 2'd0;
   localparam logic [1:0] ST_IDLE   = 2'd1;
   localparam logic [1:0] ST_SCAN   = 2'd2;
   localparam logic [1:0] ST_DECIDE = 2'd3;

   logic [1:0]   state_ff, state_in;
   logic [IW-1:0] clr_addr_ff, clr_addr_in;
   logic [sxlt_pkg::REQ_TYPE_W-1:0] type_ff, type_in;
   logic [KW-1:0] key_ff, key_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [sxlt_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [sxlt_pkg::LOCK_COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   logic          req_accept;
   logic          load;

   logic          ram_wr_en;
   logic [IW-1:0] ram_wr_addr;
   logic [WW-1:0] ram_wr_data;
   logic          ram_rd_en;
   logic [IW-1:0] ram_rd_addr;
   logic [WW-1:0] ram_rd_data;

   sxlt_pkg::scan_flags_type scan_flags;
   logic [IW-1:0]         hit_idx;
   logic signed [CW-1:0]  hit_count;
   logic [IW-1:0]         free_idx;

   // update decision
   logic                  upd_wr;
   logic [IW-1:0]         upd_idx;
   logic                  upd_valid;
   logic signed [CW-1:0]  upd_count;
   logic signed [CW-1:0]  cur_count;
   logic signed [CW-1:0]  res_count;
   logic [sxlt_pkg::STATUS_W-1:0] res_status;
   logic signed [XW-1:0]  res_count_x;

   sxlt_ram #(
      .WIDTH (WW),
      .DEPTH (TABLE_ENTRIES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   sxlt_scan #(
      .ENTRIES (TABLE_ENTRIES),
      .COUNT_W (CW)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .start     (req_accept),
      .key       (key_ff),
      .rd_en     (ram_rd_en),
      .rd_addr   (ram_rd_addr),
      .rd_data   (ram_rd_data),
      .flags     (scan_flags),
      .hit_idx   (hit_idx),
      .hit_count (hit_count),
      .free_idx  (free_idx)
   );

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign load       = (state_ff == ST_DECIDE) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      cur_count  = scan_flags.hit ? hit_count : '0;
      res_count  = cur_count;
      res_status = sxlt_pkg::STATUS_OK;
      upd_wr     = 1'b0;
      upd_idx    = hit_idx;
      upd_valid  = 1'b1;
      upd_count  = cur_count;

      case (type_ff)
         sxlt_pkg::REQ_SHARED: begin
            if (scan_flags.hit) begin
               if (cur_count[CW-1]) begin
                  res_status = sxlt_pkg::STATUS_CONFLICT;
               end else if (cur_count >= CNT_MAX) begin
                  res_status = sxlt_pkg::STATUS_SATURATED;
               end else begin
                  upd_wr    = 1'b1;
                  upd_count = cur_count + CNT_ONE;
                  res_count = upd_count;
               end
            end else if (!scan_flags.free_found) begin
               res_status = sxlt_pkg::STATUS_FULL;
            end else begin
               upd_wr    = 1'b1;
               upd_idx   = free_idx;
               upd_count = CNT_ONE;
               res_count = CNT_ONE;
            end
         end
         sxlt_pkg::REQ_EXCLUSIVE: begin
            if (scan_flags.hit) begin
               if (cur_count > CNT_ONE) begin
                  res_status = sxlt_pkg::STATUS_CONFLICT;
               end else begin
                  upd_wr    = 1'b1;
                  upd_count = CNT_EXCL;
                  res_count = CNT_EXCL;
               end
            end else if (!scan_flags.free_found) begin
               res_status = sxlt_pkg::STATUS_FULL;
            end else begin
               upd_wr    = 1'b1;
               upd_idx   = free_idx;
               upd_count = CNT_EXCL;
               res_count = CNT_EXCL;
            end
         end
         sxlt_pkg::REQ_UNLOCK: begin
            if (scan_flags.hit) begin
               upd_wr = 1'b1;
               if (cur_count > CNT_ONE) begin
                  upd_count = cur_count - CNT_ONE;
                  res_count = upd_count;
               end else begin
                  // last holder or exclusive owner leaves: free the entry
                  upd_valid = 1'b0;
                  upd_count = '0;
                  res_count = '0;
               end
            end
         end
         default: begin
            // unused code: report current count only
         end
      endcase
   end

   assign res_count_x = XW'(res_count);

   always_comb begin
      if (state_ff == ST_CLEAR) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clr_addr_ff;
         ram_wr_data = '0;
      end else begin
         ram_wr_en   = load && upd_wr;
         ram_wr_addr = upd_idx;
         ram_wr_data = {upd_valid, key_ff, upd_count};
      end
   end

   always_comb begin
      state_in      = state_ff;
      clr_addr_in   = clr_addr_ff;
      type_in       = type_ff;
      key_in        = key_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + IW'(1);
            if (clr_addr_ff == LAST_IDX) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               type_in  = req_type;
               key_in   = req_block_key;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_flags.done) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (load) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status;
               rsp_count_in  = res_count_x[sxlt_pkg::LOCK_COUNT_W-1:0];
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      type_ff       <= type_in;
      key_ff        <= key_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_lock_count = rsp_count_ff;

   // reset always starts the clearing pass
   a_reset_clears : assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("request taken during clearing pass");

   // a waiting word is never overwritten
   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      load |-> !(rsp_valid_ff && rsp_stall))
      else $error("output word overwritten");

   // no table update while the scan still reads
   a_no_write_in_scan : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> !ram_wr_en)
      else $error("table written during scan");

   // scan completes only for a request in flight
   a_done_in_scan : assert property (@(posedge clock) disable iff (reset)
      scan_flags.done |-> (state_ff == ST_SCAN))
      else $error("scan done outside scan state");

   // a known key never reports a full table
   a_full_only_on_miss : assert property (@(posedge clock) disable iff (reset)
      (load && (res_status == sxlt_pkg::STATUS_FULL)) |-> !scan_flags.hit)
      else $error("full status on a hit");

endmodule
